### rtl/absel_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// absel_pkg
// Shared types and codes for the A/B boot slot selector.
// ----------------------------------------------------------------------------
package absel_pkg;

    // Parameter defaults.
    localparam int BOARD_DEPTH_DEFAULT   = 8;
    localparam int ATTEMPT_WIDTH_DEFAULT = 8;

    // Action codes.
    localparam logic [2:0] ACT_SELECT    = 3'd0;
    localparam logic [2:0] ACT_SET_PART  = 3'd1;
    localparam logic [2:0] ACT_READ_REG  = 3'd2;
    localparam logic [2:0] ACT_WRITE_REG = 3'd3;
    localparam logic [2:0] ACT_LOAD      = 3'd4;

    // Partition targets for the set action.
    localparam logic [1:0] TGT_A    = 2'd0;
    localparam logic [1:0] TGT_B    = 2'd1;
    localparam logic [1:0] TGT_NONE = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_ROLLBACK_FAIL = 3'd1;
    localparam logic [2:0] ST_NO_ACTIVE     = 3'd2;
    localparam logic [2:0] ST_NOT_BOOTABLE  = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX     = 3'd4;

    // Slot codes; they equal the slot's bit in the masks.
    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_A    = 2'd1;
    localparam logic [1:0] SLOT_B    = 2'd2;

    // Rollback error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_A_ROLL = 2'd1;
    localparam logic [1:0] ERR_B_ROLL = 2'd2;
    localparam logic [1:0] ERR_UNUSED = 2'd3;

    // One request.
    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  target;
        logic [7:0]  reg_index;
        logic [31:0] reg_value;
        logic [1:0]  load_enable;
        logic [1:0]  load_verified;
        logic [1:0]  load_error;
        logic [7:0]  load_attempts;
    } in_t;

    // One result.
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  boot_slot;
        logic        commit;
        logic [31:0] read_value;
        logic [1:0]  enable_now;
        logic [1:0]  verified_now;
        logic [1:0]  error_now;
        logic [7:0]  attempts_left;
    } out_t;

endpackage
`default_nettype wire

### rtl/ab_boot_slot_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ab_boot_slot_selector
// A/B boot state keeper: slot selection with an attempt counter and rollback,
// partition setting, a small board register file and state image loading.
//
//   Channel  Direction  Handshake           Payload
//   in       sink       in_valid/in_stall   in_req   (absel_pkg::in_t)
//   out      source     out_valid/out_stall out_rsp  (absel_pkg::out_t)
//   cfg      sink       cfg_write_en        cfg_write_data (speculative rollback)
//
// Each request's state update and result are formed by one level of logic
// and land in the state and result registers together.
// A request is taken in every cycle while the result register is empty or
// being drained; a stalled result holds the input side only.
// Reset clears all state, including the board registers, at once.
// ----------------------------------------------------------------------------
module ab_boot_slot_selector #(
    parameter int BOARD_DEPTH   = absel_pkg::BOARD_DEPTH_DEFAULT,
    parameter int ATTEMPT_WIDTH = absel_pkg::ATTEMPT_WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic             cfg_write_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire absel_pkg::in_t   in_req,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output absel_pkg::out_t       out_rsp
);

    localparam int IDX_W = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
    localparam int CMP_W = (ATTEMPT_WIDTH > 8) ? ATTEMPT_WIDTH : 8;

    // State registers.
    logic                     spec_reg;
    logic [1:0]               enable_reg,   enable_next;
    logic [1:0]               verified_reg, verified_next;
    logic [1:0]               error_reg,    error_next;
    logic [ATTEMPT_WIDTH-1:0] attempts_reg, attempts_next;
    logic [31:0]              board_reg [BOARD_DEPTH];
    logic                     out_valid_reg;
    absel_pkg::out_t          out_reg, out_next;

    logic             accept;
    logic             idx_ok;
    logic [IDX_W-1:0] idx;
    logic [1:0]       me, other, err_code;
    logic [CMP_W-1:0] load_ext, max_ext;

    // Handshake: take a request whenever the result register can move on.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    assign idx_ok   = {1'b0, in_req.reg_index} < 9'(BOARD_DEPTH);
    assign idx      = in_req.reg_index[IDX_W-1:0];
    assign load_ext = CMP_W'(in_req.load_attempts);
    assign max_ext  = CMP_W'({ATTEMPT_WIDTH{1'b1}});

    // Next state and result for the request at the input.
    always_comb
    begin
        enable_next   = enable_reg;
        verified_next = verified_reg;
        error_next    = error_reg;
        attempts_next = attempts_reg;
        out_next      = '0;
        me            = absel_pkg::SLOT_A;
        other         = absel_pkg::SLOT_B;
        err_code      = absel_pkg::ERR_A_ROLL;
        if (!enable_reg[0])
        begin
            me       = absel_pkg::SLOT_B;
            other    = absel_pkg::SLOT_A;
            err_code = absel_pkg::ERR_B_ROLL;
        end

        unique case (in_req.action)
            absel_pkg::ACT_SELECT:
            begin
                if (enable_reg == 2'b00)
                begin
                    out_next.status = absel_pkg::ST_NO_ACTIVE;
                end
                else if ((verified_reg & me) != 2'b00)
                begin
                    out_next.boot_slot = me;
                end
                else if (attempts_reg != '0)
                begin
                    // Unverified slot spends one attempt.
                    attempts_next      = attempts_reg - ATTEMPT_WIDTH'(1);
                    out_next.commit    = 1'b1;
                    out_next.boot_slot = me;
                end
                else if ((verified_reg & other) == 2'b00 && !spec_reg)
                begin
                    out_next.status = absel_pkg::ST_ROLLBACK_FAIL;
                end
                else
                begin
                    // Roll back; an unverified partner gets one attempt.
                    if ((verified_reg & other) == 2'b00)
                    begin
                        attempts_next = ATTEMPT_WIDTH'(1);
                    end
                    enable_next        = other;
                    error_next         = err_code;
                    out_next.commit    = 1'b1;
                    out_next.boot_slot = other;
                end
            end
            absel_pkg::ACT_SET_PART:
            begin
                error_next = absel_pkg::ERR_NONE;
                case (in_req.target)
                    absel_pkg::TGT_A:
                    begin
                        enable_next     = absel_pkg::SLOT_A;
                        verified_next   = absel_pkg::SLOT_A;
                        out_next.commit = 1'b1;
                    end
                    absel_pkg::TGT_B:
                    begin
                        enable_next     = absel_pkg::SLOT_B;
                        verified_next   = absel_pkg::SLOT_B;
                        out_next.commit = 1'b1;
                    end
                    absel_pkg::TGT_NONE:
                    begin
                        enable_next     = 2'b00;
                        verified_next   = 2'b00;
                        out_next.commit = 1'b1;
                    end
                    default:
                    begin
                        enable_next     = 2'b00;
                        verified_next   = 2'b00;
                        out_next.status = absel_pkg::ST_NOT_BOOTABLE;
                    end
                endcase
            end
            absel_pkg::ACT_READ_REG:
            begin
                if (!idx_ok)
                begin
                    out_next.status = absel_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    out_next.read_value = board_reg[idx];
                end
            end
            absel_pkg::ACT_WRITE_REG:
            begin
                if (!idx_ok)
                begin
                    out_next.status = absel_pkg::ST_BAD_INDEX;
                end
                else
                begin
                    out_next.commit = 1'b1;
                end
            end
            absel_pkg::ACT_LOAD:
            begin
                enable_next   = in_req.load_enable;
                verified_next = in_req.load_verified;
                error_next    = (in_req.load_error == absel_pkg::ERR_UNUSED) ?
                                absel_pkg::ERR_NONE : in_req.load_error;
                attempts_next = (load_ext > max_ext) ? {ATTEMPT_WIDTH{1'b1}} :
                                ATTEMPT_WIDTH'(load_ext);
            end
            default:
            begin
            end
        endcase

        // Boot slot on all but select is the single enabled slot, if any.
        if (in_req.action != absel_pkg::ACT_SELECT)
        begin
            if (enable_next == absel_pkg::SLOT_A || enable_next == absel_pkg::SLOT_B)
            begin
                out_next.boot_slot = enable_next;
            end
            else
            begin
                out_next.boot_slot = absel_pkg::SLOT_NONE;
            end
        end

        out_next.enable_now    = enable_next;
        out_next.verified_now  = verified_next;
        out_next.error_now     = error_next;
        out_next.attempts_left = 8'(CMP_W'(attempts_next));
    end

    // State, board registers and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_reg      <= 1'b0;
            enable_reg    <= 2'b00;
            verified_reg  <= 2'b00;
            error_reg     <= absel_pkg::ERR_NONE;
            attempts_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < BOARD_DEPTH; i++)
            begin
                board_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                spec_reg <= cfg_write_data;
            end
            if (accept)
            begin
                enable_reg   <= enable_next;
                verified_reg <= verified_next;
                error_reg    <= error_next;
                attempts_reg <= attempts_next;
                out_reg      <= out_next;
                if (in_req.action == absel_pkg::ACT_WRITE_REG && idx_ok)
                begin
                    board_reg[idx] <= in_req.reg_value;
                end
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Checks on the result register.
    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_rsp.commit |-> out_rsp.status == absel_pkg::ST_OK)
        else $error("commit set on a failing request");

    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_rsp.status == absel_pkg::ST_ROLLBACK_FAIL ||
                      out_rsp.status == absel_pkg::ST_NO_ACTIVE)
        |-> out_rsp.boot_slot == absel_pkg::SLOT_NONE)
        else $error("slot reported on a failed selection");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_rsp.error_now != absel_pkg::ERR_UNUSED)
        else $error("unused rollback error code held");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty result register");

    a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> out_rsp.enable_now == enable_reg &&
                          out_rsp.error_now == error_reg)
        else $error("result state differs from held state");

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the A/B boot slot selector. A behavioral shadow of
// the boot state predicts every result; directed cases cover the corner cases
// and random boot sequences with random back-pressure cover the rest, in both
// strict and speculative rollback mode.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_BOARD      = absel_pkg::BOARD_DEPTH_DEFAULT;
    localparam int BOARD_IDX_W    = (NUM_BOARD > 1) ? $clog2(NUM_BOARD) : 1;
    localparam int STALL_LIMIT    = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 4;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] TGT_UNKNOWN    = 2'd3;
    localparam logic [2:0] ACT_SPARE_LO   = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI   = 3'd7;
    localparam logic       MODE_STRICT    = 1'b0;
    localparam logic       MODE_SPECULATE = 1'b1;

    logic            clk            = 1'b0;
    logic            rst_n          = 1'b0;
    logic            cfg_write_en   = 1'b0;
    logic            cfg_write_data = 1'b0;
    logic            in_valid       = 1'b0;
    logic            in_stall;
    absel_pkg::in_t  in_req         = '0;
    logic            out_valid;
    logic            out_stall      = 1'b0;
    absel_pkg::out_t out_rsp;

    // Shadow copy of the boot state.
    logic        shadow_speculative = 1'b0;
    logic [1:0]  shadow_enable      = '0;
    logic [1:0]  shadow_verified    = '0;
    logic [1:0]  shadow_error       = absel_pkg::ERR_NONE;
    logic [7:0]  shadow_attempts    = '0;
    logic [31:0] shadow_board [NUM_BOARD];

    absel_pkg::out_t pending_results [$];

    int  error_count     = 0;
    int  request_count   = 0;
    int  result_count    = 0;
    int  rollback_count  = 0;
    int  refused_count   = 0;
    int  hold_requests   = 0;
    int  holds_served    = 0;
    int  stall_left      = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b0;

    ab_boot_slot_selector i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_req         (in_req),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_rsp        (out_rsp)
    );

    always #5 clk = ~clk;

    initial
    begin
        foreach (shadow_board[i])
            shadow_board[i] = '0;
    end

    // Works out the result of one request and advances the shadow state.
    function automatic absel_pkg::out_t predict_boot_step(absel_pkg::in_t req);
        absel_pkg::out_t r;
        logic [1:0]      mine;
        logic [1:0]      other;
        logic [1:0]      roll_code;
        r = '0;
        case (req.action) inside
            absel_pkg::ACT_SELECT:
            begin
                // Slot A is tested first when both are enabled.
                if (shadow_enable[0])
                begin
                    mine = absel_pkg::SLOT_A;
                    other = absel_pkg::SLOT_B;
                    roll_code = absel_pkg::ERR_A_ROLL;
                end
                else
                begin
                    mine = absel_pkg::SLOT_B;
                    other = absel_pkg::SLOT_A;
                    roll_code = absel_pkg::ERR_B_ROLL;
                end
                if (shadow_enable == absel_pkg::SLOT_NONE)
                    r.status = absel_pkg::ST_NO_ACTIVE;
                else if ((shadow_verified & mine) != 0)
                    r.boot_slot = mine;
                else if (shadow_attempts != 0)
                begin
                    shadow_attempts = shadow_attempts - 8'd1;
                    r.commit = 1'b1;
                    r.boot_slot = mine;
                end
                else if ((shadow_verified & other) == 0 && !shadow_speculative)
                begin
                    r.status = absel_pkg::ST_ROLLBACK_FAIL;
                    refused_count++;
                end
                else
                begin
                    // A speculative rollback gives the other slot one try.
                    if ((shadow_verified & other) == 0)
                        shadow_attempts = 8'd1;
                    shadow_enable = other;
                    shadow_error = roll_code;
                    r.commit = 1'b1;
                    r.boot_slot = other;
                    rollback_count++;
                end
            end
            absel_pkg::ACT_SET_PART:
            begin
                shadow_error = absel_pkg::ERR_NONE;
                case (req.target)
                    absel_pkg::TGT_A:
                    begin
                        shadow_enable = absel_pkg::SLOT_A;
                        shadow_verified = absel_pkg::SLOT_A;
                        r.commit = 1'b1;
                    end
                    absel_pkg::TGT_B:
                    begin
                        shadow_enable = absel_pkg::SLOT_B;
                        shadow_verified = absel_pkg::SLOT_B;
                        r.commit = 1'b1;
                    end
                    absel_pkg::TGT_NONE:
                    begin
                        shadow_enable = absel_pkg::SLOT_NONE;
                        shadow_verified = absel_pkg::SLOT_NONE;
                        r.commit = 1'b1;
                    end
                    default:
                    begin
                        shadow_enable = absel_pkg::SLOT_NONE;
                        shadow_verified = absel_pkg::SLOT_NONE;
                        r.status = absel_pkg::ST_NOT_BOOTABLE;
                    end
                endcase
            end
            absel_pkg::ACT_READ_REG, absel_pkg::ACT_WRITE_REG:
            begin
                if (int'(req.reg_index) >= NUM_BOARD)
                    r.status = absel_pkg::ST_BAD_INDEX;
                else if (req.action == absel_pkg::ACT_READ_REG)
                    r.read_value = shadow_board[req.reg_index[BOARD_IDX_W-1:0]];
                else
                begin
                    shadow_board[req.reg_index[BOARD_IDX_W-1:0]] = req.reg_value;
                    r.commit = 1'b1;
                end
            end
            absel_pkg::ACT_LOAD:
            begin
                // With an 8-bit counter the loaded count never saturates.
                shadow_enable = req.load_enable;
                shadow_verified = req.load_verified;
                shadow_error = (req.load_error == absel_pkg::ERR_UNUSED) ?
                               absel_pkg::ERR_NONE : req.load_error;
                shadow_attempts = req.load_attempts;
            end
            default:
                ;
        endcase
        if (req.action != absel_pkg::ACT_SELECT)
        begin
            if (shadow_enable == absel_pkg::SLOT_A || shadow_enable == absel_pkg::SLOT_B)
                r.boot_slot = shadow_enable;
            else
                r.boot_slot = absel_pkg::SLOT_NONE;
        end
        r.enable_now = shadow_enable;
        r.verified_now = shadow_verified;
        r.error_now = shadow_error;
        r.attempts_left = shadow_attempts;
        return r;
    endfunction

    function automatic absel_pkg::in_t make_request(logic [2:0] action, logic [1:0] target,
                                                    logic [7:0] index, logic [31:0] value,
                                                    logic [1:0] en, logic [1:0] ver,
                                                    logic [1:0] err, logic [7:0] tries);
        absel_pkg::in_t req;
        req.action = action;
        req.target = target;
        req.reg_index = index;
        req.reg_value = value;
        req.load_enable = en;
        req.load_verified = ver;
        req.load_error = err;
        req.load_attempts = tries;
        return req;
    endfunction

    // Random request; fields the action ignores still carry random bits.
    function automatic absel_pkg::in_t random_request();
        absel_pkg::in_t req;
        logic [63:0]    raw;
        int             pick;
        raw = {$urandom(), $urandom()};
        req = raw[$bits(absel_pkg::in_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.action = absel_pkg::ACT_SELECT;
        else if (pick < 45)
            req.action = absel_pkg::ACT_SET_PART;
        else if (pick < 58)
            req.action = absel_pkg::ACT_READ_REG;
        else if (pick < 71)
            req.action = absel_pkg::ACT_WRITE_REG;
        else if (pick < 94)
            req.action = absel_pkg::ACT_LOAD;
        else
            req.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if ($urandom_range(0, 4) != 0)
            req.reg_index = 8'($urandom_range(0, NUM_BOARD - 1));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            req.load_attempts = 8'($urandom_range(0, 2));
        else if (pick == 6)
            req.load_attempts = 8'hFF;
        return req;
    endfunction

    // Offers one request, with an optional idle burst first, until it is taken.
    task automatic send_request(input absel_pkg::in_t req);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid <= 1'b1;
        in_req <= req;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_boot_step(req));
        request_count++;
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rollback_mode(input logic speculative);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= speculative;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        shadow_speculative = speculative;
    endtask

    // A stored image followed by a run of boot selections.
    task automatic boot_sequence();
        absel_pkg::in_t req;
        int             count;
        req = random_request();
        req.action = absel_pkg::ACT_LOAD;
        send_request(req);
        count = $urandom_range(2, 6);
        repeat (count)
        begin
            req = random_request();
            req.action = ($urandom_range(0, 7) == 0) ? absel_pkg::ACT_SET_PART :
                                                      absel_pkg::ACT_SELECT;
            send_request(req);
        end
    endtask

    // Corner cases: empty slots, register file bounds, every partition
    // target, rollback in both modes and the spare action codes.
    task automatic test_directed();
        idle_on = 1'b0;
        write_rollback_mode(MODE_STRICT);
        send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_WRITE_REG, absel_pkg::TGT_A, 8'd0,
                                  32'hFFFF_FFFF, 2'b11, 2'b11, absel_pkg::ERR_UNUSED, 8'hFF));
        send_request(make_request(absel_pkg::ACT_READ_REG, absel_pkg::TGT_B, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_WRITE_REG, absel_pkg::TGT_A,
                                  8'(NUM_BOARD - 1), 32'h0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_READ_REG, absel_pkg::TGT_A,
                                  8'(NUM_BOARD), '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_WRITE_REG, absel_pkg::TGT_A, 8'hFF,
                                  32'hA5A5_5A5A, 2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_SET_PART, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_SET_PART, absel_pkg::TGT_B, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_SET_PART, absel_pkg::TGT_NONE, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_SET_PART, TGT_UNKNOWN, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        // Both slots enabled and unverified: strict rollback is refused.
        send_request(make_request(absel_pkg::ACT_LOAD, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b11, 2'b00, absel_pkg::ERR_UNUSED, 8'd0));
        send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        // Attempts run out, then rollback to an unverified slot fails.
        send_request(make_request(absel_pkg::ACT_LOAD, absel_pkg::TGT_A, 8'd0, '0,
                                  absel_pkg::SLOT_A, 2'b00, absel_pkg::ERR_NONE, 8'd2));
        repeat (3)
            send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                      2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        // Rollback to a verified slot, then a verified boot.
        send_request(make_request(absel_pkg::ACT_LOAD, absel_pkg::TGT_A, 8'd0, '0,
                                  absel_pkg::SLOT_A, absel_pkg::SLOT_B,
                                  absel_pkg::ERR_NONE, 8'd0));
        repeat (2)
            send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                      2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(absel_pkg::ACT_LOAD, absel_pkg::TGT_A, 8'd0, '0,
                                  absel_pkg::SLOT_B, absel_pkg::SLOT_A,
                                  absel_pkg::ERR_B_ROLL, 8'hFF));
        send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(ACT_SPARE_LO, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        send_request(make_request(ACT_SPARE_HI, absel_pkg::TGT_A, 8'd0, '0,
                                  2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        drain_results();
        // Speculative mode: rollback, spend the granted attempt, roll back again.
        write_rollback_mode(MODE_SPECULATE);
        send_request(make_request(absel_pkg::ACT_LOAD, absel_pkg::TGT_A, 8'd0, '0,
                                  absel_pkg::SLOT_A, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        repeat (3)
            send_request(make_request(absel_pkg::ACT_SELECT, absel_pkg::TGT_A, 8'd0, '0,
                                      2'b00, 2'b00, absel_pkg::ERR_NONE, 8'd0));
        drain_results();
    endtask

    // Random requests and boot sequences with idling on both sides.
    task automatic test_random_traffic(input logic speculative, input int count);
        int start;
        drain_results();
        write_rollback_mode(speculative);
        idle_on = 1'b1;
        start = request_count;
        while (request_count - start < count)
        begin
            if ($urandom_range(0, 2) != 0)
                boot_sequence();
            else
                send_request(random_request());
        end
        drain_results();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // then the sender waits for every result before going on.
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_requests++;
        repeat (24)
            send_request(random_request());
        drain_results();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream(input logic speculative, input int count);
        drain_results();
        write_rollback_mode(speculative);
        idle_on = 1'b0;
        repeat (count / 5)
            boot_sequence();
        drain_results();
    endtask

    // Receiver: random stall bursts and an occasional long hold.
    always @(negedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
            error_count++;
        end
    endfunction

    // Compares each delivered result with the oldest prediction.
    always @(posedge clk)
    begin
        absel_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual 0x%0h", $time, out_rsp);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                result_count++;
                check_field("status", 32'(want.status), 32'(out_rsp.status));
                check_field("boot_slot", 32'(want.boot_slot), 32'(out_rsp.boot_slot));
                check_field("commit", 32'(want.commit), 32'(out_rsp.commit));
                check_field("read_value", want.read_value, out_rsp.read_value);
                check_field("enable_now", 32'(want.enable_now), 32'(out_rsp.enable_now));
                check_field("verified_now", 32'(want.verified_now),
                            32'(out_rsp.verified_now));
                check_field("error_now", 32'(want.error_now), 32'(out_rsp.error_now));
                check_field("attempts_left", 32'(want.attempts_left),
                            32'(out_rsp.attempts_left));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(MODE_SPECULATE, 350);
        test_backpressure();
        test_random_traffic(MODE_STRICT, 350);
        test_steady_stream(MODE_SPECULATE, 150);
        if (pending_results.size() != 0)
            error_count++;
        $display("Covered %0d requests and %0d results in strict and speculative mode,",
                 request_count, result_count);
        $display("with %0d rollbacks and %0d refused rollbacks.", rollback_count, refused_count);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
